// ===== sv/env_sensor_advert_decode_average_assert.svh =====
// Assertion helpers shared by the decoder modules.
`ifndef ENV_SENSOR_ADVERT_DECODE_AVERAGE_ASSERT_SVH
`define ENV_SENSOR_ADVERT_DECODE_AVERAGE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ESAD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ESAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/esad_pkg.sv =====
`default_nettype none

package esad_pkg;

    // Parameter defaults
    localparam int MIN_PACKET_BYTES_DEF = 24;
    localparam int COUNT_BITS_DEF       = 16;
    localparam int QUEUE_DEPTH_DEF      = 2;

    // Packet layout
    localparam logic [7:0] HDR0 = 8'h99;
    localparam logic [7:0] HDR1 = 8'h04;
    localparam logic [7:0] HDR2 = 8'h05;
    localparam logic [4:0] IDX_HDR0        = 5'd0;
    localparam logic [4:0] IDX_HDR1        = 5'd1;
    localparam logic [4:0] IDX_HDR2        = 5'd2;
    localparam logic [4:0] IDX_FIELD_FIRST = 5'd3;
    localparam logic [4:0] IDX_FIELD_LAST  = 5'd8;
    localparam logic [4:0] INDEX_MAX       = 5'd31;

    localparam logic [16:0] PRESSURE_OFFSET = 17'd50000;

    // Quotient width: every average fits in 17 bits
    localparam int AVG_BITS = 17;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_HEADER = 2'd2,
        ST_ADDR   = 2'd3
    } status_t;

    typedef enum logic {
        ACT_DATA  = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    // Per-packet report fields that do not depend on the count width
    typedef struct packed {
        status_t            status;
        logic signed [15:0] temp;
        logic [15:0]        hum;
        logic [16:0]        press;
    } last_vals_t;

endpackage

`default_nettype wire

// ===== sv/esad_fifo.sv =====
`default_nettype none

`include "env_sensor_advert_decode_average_assert.svh"

module esad_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = esad_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ESAD_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push && !pop, !full, "queue overflow")
    `ESAD_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, !empty, "queue underflow")

endmodule

`default_nettype wire

// ===== sv/esad_front.sv =====
`default_nettype none

module esad_front #(
    parameter int MIN_PACKET_BYTES = esad_pkg::MIN_PACKET_BYTES_DEF,
    parameter int COUNT_BITS       = esad_pkg::COUNT_BITS_DEF,
    parameter int SUM_W            = esad_pkg::AVG_BITS + esad_pkg::COUNT_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [47:0]              allowed_mac,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     action,
    input  wire logic [7:0]               data_byte,
    input  wire logic                     byte_last,
    input  wire logic [47:0]              source_mac,
    input  wire logic                     q_full,
    output logic                          q_push,
    output esad_pkg::last_vals_t          q_last,
    output logic [COUNT_BITS-1:0]         q_count,
    output logic signed [SUM_W-1:0]       q_temp_sum,
    output logic [SUM_W-1:0]              q_hum_sum,
    output logic [SUM_W-1:0]              q_press_sum
);

    logic [4:0]                  byte_index_reg, byte_index_next;
    logic                        header_ok_reg, header_ok_next;
    logic [47:0]                 fields_reg, fields_next;
    logic signed [15:0]          last_temp_reg, last_temp_next;
    logic [15:0]                 last_hum_reg, last_hum_next;
    logic [16:0]                 last_press_reg, last_press_next;
    logic signed [SUM_W-1:0]     temp_sum_reg, temp_sum_next;
    logic [SUM_W-1:0]            hum_sum_reg, hum_sum_next;
    logic [SUM_W-1:0]            press_sum_reg, press_sum_next;
    logic [COUNT_BITS-1:0]       count_reg, count_next;

    logic                        accept;
    logic                        is_clear;
    logic                        hdr_bad;
    logic                        hdr_upd;
    logic [47:0]                 fields_upd;
    logic signed [15:0]          t_val;
    logic [15:0]                 h_val;
    logic [16:0]                 p_val;
    esad_pkg::status_t           status;
    logic                        take;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_clear = (action == esad_pkg::ACT_CLEAR);
    assign q_push   = accept && !is_clear && byte_last;

    // Check header bytes and collect the value bytes
    always_comb begin
        hdr_bad = ((byte_index_reg == esad_pkg::IDX_HDR0) && (data_byte != esad_pkg::HDR0))
               || ((byte_index_reg == esad_pkg::IDX_HDR1) && (data_byte != esad_pkg::HDR1))
               || ((byte_index_reg == esad_pkg::IDX_HDR2) && (data_byte != esad_pkg::HDR2));
        hdr_upd = header_ok_reg && !hdr_bad;
        if ((byte_index_reg >= esad_pkg::IDX_FIELD_FIRST)
                && (byte_index_reg <= esad_pkg::IDX_FIELD_LAST)) begin
            fields_upd = {fields_reg[39:0], data_byte};
        end else begin
            fields_upd = fields_reg;
        end
        t_val = fields_upd[47:32];
        h_val = fields_upd[31:16];
        p_val = {1'b0, fields_upd[15:0]} + esad_pkg::PRESSURE_OFFSET;
    end

    // Classify the packet at its last byte
    always_comb begin
        if (byte_index_reg < 5'(MIN_PACKET_BYTES - 1)) begin
            status = esad_pkg::ST_SHORT;
        end else if (!hdr_upd) begin
            status = esad_pkg::ST_HEADER;
        end else if (source_mac != allowed_mac) begin
            status = esad_pkg::ST_ADDR;
        end else begin
            status = esad_pkg::ST_OK;
        end
        take = (status == esad_pkg::ST_OK);
    end

    // Next state for data bytes, last bytes and clears
    always_comb begin
        byte_index_next = byte_index_reg;
        header_ok_next  = header_ok_reg;
        fields_next     = fields_reg;
        last_temp_next  = last_temp_reg;
        last_hum_next   = last_hum_reg;
        last_press_next = last_press_reg;
        temp_sum_next   = temp_sum_reg;
        hum_sum_next    = hum_sum_reg;
        press_sum_next  = press_sum_reg;
        count_next      = count_reg;
        if (is_clear) begin
            temp_sum_next  = '0;
            hum_sum_next   = '0;
            press_sum_next = '0;
            count_next     = '0;
        end else if (byte_last) begin
            byte_index_next = '0;
            header_ok_next  = 1'b1;
            fields_next     = '0;
            if (take) begin
                last_temp_next  = t_val;
                last_hum_next   = h_val;
                last_press_next = p_val;
                if (count_reg != '1) begin
                    temp_sum_next  = temp_sum_reg + SUM_W'(t_val);
                    hum_sum_next   = hum_sum_reg + SUM_W'(h_val);
                    press_sum_next = press_sum_reg + SUM_W'(p_val);
                    count_next     = count_reg + 1'b1;
                end
            end
        end else begin
            byte_index_next = (byte_index_reg == esad_pkg::INDEX_MAX)
                            ? esad_pkg::INDEX_MAX : byte_index_reg + 1'b1;
            header_ok_next  = hdr_upd;
            fields_next     = fields_upd;
        end
    end

    // Snapshot handed to the back end
    always_comb begin
        q_last.status = status;
        q_last.temp   = last_temp_next;
        q_last.hum    = last_hum_next;
        q_last.press  = last_press_next;
        q_count       = count_next;
        q_temp_sum    = temp_sum_next;
        q_hum_sum     = hum_sum_next;
        q_press_sum   = press_sum_next;
    end

    // Update parser and accumulator state on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= '0;
            header_ok_reg  <= 1'b1;
            fields_reg     <= '0;
            last_temp_reg  <= '0;
            last_hum_reg   <= '0;
            last_press_reg <= '0;
            temp_sum_reg   <= '0;
            hum_sum_reg    <= '0;
            press_sum_reg  <= '0;
            count_reg      <= '0;
        end else if (accept) begin
            byte_index_reg <= byte_index_next;
            header_ok_reg  <= header_ok_next;
            fields_reg     <= fields_next;
            last_temp_reg  <= last_temp_next;
            last_hum_reg   <= last_hum_next;
            last_press_reg <= last_press_next;
            temp_sum_reg   <= temp_sum_next;
            hum_sum_reg    <= hum_sum_next;
            press_sum_reg  <= press_sum_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/esad_back.sv =====
`default_nettype none

`include "env_sensor_advert_decode_average_assert.svh"

module esad_back #(
    parameter int COUNT_BITS = esad_pkg::COUNT_BITS_DEF,
    parameter int SUM_W      = esad_pkg::AVG_BITS + esad_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_empty,
    output logic                       q_pop,
    input  wire esad_pkg::last_vals_t  q_last,
    input  wire logic [COUNT_BITS-1:0] q_count,
    input  wire logic [SUM_W-1:0]      q_temp_sum,
    input  wire logic [SUM_W-1:0]      q_hum_sum,
    input  wire logic [SUM_W-1:0]      q_press_sum,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_status,
    output logic signed [15:0]         m_last_temperature,
    output logic [15:0]                m_last_humidity,
    output logic [16:0]                m_last_pressure,
    output logic [15:0]                m_sample_count,
    output logic                       m_avg_valid,
    output logic signed [15:0]         m_avg_temperature,
    output logic [15:0]                m_avg_humidity,
    output logic [16:0]                m_avg_pressure
);

    localparam int QB    = esad_pkg::AVG_BITS;
    localparam int STEPW = $clog2(QB);
    localparam int LANES = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [STEPW-1:0]       step_reg;
    esad_pkg::last_vals_t   job_last_reg;
    logic [COUNT_BITS-1:0]  job_count_reg;
    logic                   neg_reg;
    logic [COUNT_BITS-1:0]  rem_reg [LANES];
    logic [QB-1:0]          dq_reg  [LANES];

    logic [COUNT_BITS-1:0]  rem_next [LANES];
    logic [QB-1:0]          dq_next  [LANES];
    logic [COUNT_BITS:0]    trial    [LANES];
    logic                   ge       [LANES];
    logic [SUM_W-1:0]       mag      [LANES];
    logic [QB-1:0]          temp_q;
    logic                   out_load;

    logic                   m_valid_reg;
    esad_pkg::last_vals_t   out_last_reg;
    logic [15:0]            out_count_reg;
    logic                   out_avg_valid_reg;
    logic [15:0]            out_avg_temp_reg;
    logic [15:0]            out_avg_hum_reg;
    logic [16:0]            out_avg_press_reg;

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    // Load the result once the previous one has been taken
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Magnitudes of the dividends; the temperature sum is signed
    always_comb begin
        mag[0] = q_temp_sum[SUM_W-1] ? (~q_temp_sum + SUM_W'(1)) : q_temp_sum;
        mag[1] = q_hum_sum;
        mag[2] = q_press_sum;
    end

    // One restoring division step per lane
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            trial[i]    = {rem_reg[i], dq_reg[i][QB-1]};
            ge[i]       = (trial[i] >= {1'b0, job_count_reg});
            rem_next[i] = ge[i] ? COUNT_BITS'(trial[i] - {1'b0, job_count_reg})
                                : trial[i][COUNT_BITS-1:0];
            dq_next[i]  = {dq_reg[i][QB-2:0], ge[i]};
        end
        temp_q = neg_reg ? (~dq_reg[0] + QB'(1)) : dq_reg[0];
    end

    // Sequencer, divider lanes and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        job_last_reg  <= q_last;
                        job_count_reg <= q_count;
                        neg_reg       <= q_temp_sum[SUM_W-1];
                        for (int i = 0; i < LANES; i++) begin
                            rem_reg[i] <= mag[i][SUM_W-1:QB];
                            dq_reg[i]  <= mag[i][QB-1:0];
                        end
                        step_reg  <= '0;
                        state_reg <= (q_count == '0) ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    for (int i = 0; i < LANES; i++) begin
                        rem_reg[i] <= rem_next[i];
                        dq_reg[i]  <= dq_next[i];
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEPW'(QB - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        out_last_reg   <= job_last_reg;
                        out_count_reg  <= 16'(job_count_reg);
                        if (job_count_reg != '0) begin
                            out_avg_valid_reg <= 1'b1;
                            out_avg_temp_reg  <= temp_q[15:0];
                            out_avg_hum_reg   <= dq_reg[1][15:0];
                            out_avg_press_reg <= dq_reg[2][16:0];
                        end else begin
                            out_avg_valid_reg <= 1'b0;
                            out_avg_temp_reg  <= '0;
                            out_avg_hum_reg   <= '0;
                            out_avg_press_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = out_last_reg.status;
    assign m_last_temperature = out_last_reg.temp;
    assign m_last_humidity    = out_last_reg.hum;
    assign m_last_pressure    = out_last_reg.press;
    assign m_sample_count     = out_count_reg;
    assign m_avg_valid        = out_avg_valid_reg;
    assign m_avg_temperature  = out_avg_temp_reg;
    assign m_avg_humidity     = out_avg_hum_reg;
    assign m_avg_pressure     = out_avg_press_reg;

    `ESAD_ASSERT_IMPL(a_div_nonzero, aclk, aresetn, state_reg == ST_DIV, job_count_reg != '0, "division by zero count")
    `ESAD_ASSERT_NEXT(a_div_ends, aclk, aresetn, (state_reg == ST_DIV) && (step_reg == STEPW'(QB - 1)), state_reg == ST_DONE, "division did not finish")

endmodule

`default_nettype wire

// ===== sv/env_sensor_advert_decode_average.sv =====
`default_nettype none

// Channel  | Handshake         | Payload
// ---------+-------------------+--------------------------------------------------
// input    | s_valid / s_ready | s_action, s_data_byte, s_byte_last, s_source_mac
// result   | m_valid / m_ready | m_status, last values, m_sample_count, averages
// config   | cfg_wr_en         | cfg_wr_data (allowed sender address)
//
// Bytes are taken one per cycle while the packet queue has room.
// The back end takes one packet at a time from the queue and runs it through
// three parallel restoring dividers (one quotient bit each cycle), then loads
// the result register; a packet with zero count skips the divider.
// Reset is synchronous, active low; s_ready stalls only on a full queue.

module env_sensor_advert_decode_average #(
    parameter int MIN_PACKET_BYTES = esad_pkg::MIN_PACKET_BYTES_DEF,
    parameter int COUNT_BITS       = esad_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH      = esad_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [47:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic [7:0]         s_data_byte,
    input  wire logic               s_byte_last,
    input  wire logic [47:0]        s_source_mac,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [15:0]      m_last_temperature,
    output logic [15:0]             m_last_humidity,
    output logic [16:0]             m_last_pressure,
    output logic [15:0]             m_sample_count,
    output logic                    m_avg_valid,
    output logic signed [15:0]      m_avg_temperature,
    output logic [15:0]             m_avg_humidity,
    output logic [16:0]             m_avg_pressure
);

    localparam int SUM_W   = esad_pkg::AVG_BITS + COUNT_BITS;
    localparam int LAST_W  = $bits(esad_pkg::last_vals_t);
    localparam int ENTRY_W = LAST_W + COUNT_BITS + 3 * SUM_W;

    logic [47:0]             allowed_mac_reg;

    logic                    q_push;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_empty;
    logic [ENTRY_W-1:0]      q_wr_data;
    logic [ENTRY_W-1:0]      q_rd_data;

    esad_pkg::last_vals_t    f_last;
    logic [COUNT_BITS-1:0]   f_count;
    logic signed [SUM_W-1:0] f_temp_sum;
    logic [SUM_W-1:0]        f_hum_sum;
    logic [SUM_W-1:0]        f_press_sum;

    esad_pkg::last_vals_t    b_last;
    logic [COUNT_BITS-1:0]   b_count;
    logic [SUM_W-1:0]        b_temp_sum;
    logic [SUM_W-1:0]        b_hum_sum;
    logic [SUM_W-1:0]        b_press_sum;

    // Hold the allowed sender address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allowed_mac_reg <= '0;
        end else if (cfg_wr_en) begin
            allowed_mac_reg <= cfg_wr_data;
        end
    end

    esad_front #(
        .MIN_PACKET_BYTES (MIN_PACKET_BYTES),
        .COUNT_BITS       (COUNT_BITS),
        .SUM_W            (SUM_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .allowed_mac (allowed_mac_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .action      (s_action),
        .data_byte   (s_data_byte),
        .byte_last   (s_byte_last),
        .source_mac  (s_source_mac),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_last      (f_last),
        .q_count     (f_count),
        .q_temp_sum  (f_temp_sum),
        .q_hum_sum   (f_hum_sum),
        .q_press_sum (f_press_sum)
    );

    // Pack and unpack queue entries
    assign q_wr_data = {f_last, f_count, f_temp_sum, f_hum_sum, f_press_sum};
    assign {b_last, b_count, b_temp_sum, b_hum_sum, b_press_sum} = q_rd_data;

    esad_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    esad_back #(
        .COUNT_BITS (COUNT_BITS),
        .SUM_W      (SUM_W)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_empty            (q_empty),
        .q_pop              (q_pop),
        .q_last             (b_last),
        .q_count            (b_count),
        .q_temp_sum         (b_temp_sum),
        .q_hum_sum          (b_hum_sum),
        .q_press_sum        (b_press_sum),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_last_temperature (m_last_temperature),
        .m_last_humidity    (m_last_humidity),
        .m_last_pressure    (m_last_pressure),
        .m_sample_count     (m_sample_count),
        .m_avg_valid        (m_avg_valid),
        .m_avg_temperature  (m_avg_temperature),
        .m_avg_humidity     (m_avg_humidity),
        .m_avg_pressure     (m_avg_pressure)
    );

endmodule

`default_nettype wire
